[src/mlpq_pkg.sv]
package mlpq_pkg;

  localparam int NUM_LEVELS_DEF   = 8;
  localparam int LEVEL_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH      = 3'd0,
    FN_PEEK      = 3'd1,
    FN_POP_TOP   = 3'd2,
    FN_POP_EXACT = 3'd3,
    FN_POP_GE    = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // response info decided at request accept, completed with read data
  typedef struct packed {
    logic               take;
    status_e            status;
    logic [LEVEL_W-1:0] served;
  } rsp_info_t;

endpackage

[src/mlpq_if.sv]
interface mlpq_req_if;
  logic                         valid;
  logic                         ready;
  logic [mlpq_pkg::FUNC_W-1:0]  func;
  logic [mlpq_pkg::LEVEL_W-1:0] level;
  logic [mlpq_pkg::DATA_W-1:0]  payload;

  modport source (output valid, output func, output level, output payload, input ready);
  modport sink   (input valid, input func, input level, input payload, output ready);
endinterface

interface mlpq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mlpq_pkg::STATUS_W-1:0] status;
  logic [mlpq_pkg::DATA_W-1:0]   data_out;
  logic [mlpq_pkg::LEVEL_W-1:0]  served_level;

  modport source (output valid, output status, output data_out, output served_level,
                  input ready);
  modport sink   (input valid, input status, input data_out, input served_level,
                  output ready);
endinterface

[src/mlpq_store.sv]
module mlpq_store #(
  parameter int DEPTH = mlpq_pkg::NUM_LEVELS_DEF * mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int WIDTH = mlpq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mlpq_ctrl.sv]
module mlpq_ctrl #(
  parameter int NUM_LEVELS  = mlpq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
  localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [mlpq_pkg::FUNC_W-1:0]  func_i,
  input  logic [mlpq_pkg::LEVEL_W-1:0] level_i,
  output logic                         mem_we_o,
  output logic                         mem_re_o,
  output logic [AW-1:0]                mem_addr_o,
  output mlpq_pkg::rsp_info_t          info_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int PW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CW = $clog2(LEVEL_DEPTH + 1);

  logic [PW-1:0] head_q [NUM_LEVELS];
  logic [PW-1:0] tail_q [NUM_LEVELS];
  logic [CW-1:0] cnt_q  [NUM_LEVELS];

  logic                 level_ok;
  logic [LW-1:0]        req_lvl;
  logic [LW-1:0]        floor_lvl;
  logic [NUM_LEVELS-1:0] nonempty;
  logic                 found;
  logic [LW-1:0]        hi_lvl;
  logic [LW-1:0]        sel_lvl;
  logic                 do_push;
  logic                 do_take;
  logic                 do_pop;
  logic [PW-1:0]        ptr;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
    end
  end

  assign level_ok  = (32'(level_i) < NUM_LEVELS);
  assign req_lvl   = LW'(level_i);
  assign floor_lvl = (mlpq_pkg::func_e'(func_i) == mlpq_pkg::FN_POP_GE) ? req_lvl : '0;

  // highest non-empty level at or above floor
  always_comb begin
    found  = 1'b0;
    hi_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i] && (LW'(i) >= floor_lvl)) begin
        found  = 1'b1;
        hi_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    do_push     = 1'b0;
    do_take     = 1'b0;
    do_pop      = 1'b0;
    sel_lvl     = hi_lvl;
    info_o.take   = 1'b0;
    info_o.status = mlpq_pkg::ST_EMPTY;
    info_o.served = '0;
    case (mlpq_pkg::func_e'(func_i))
      mlpq_pkg::FN_PUSH: begin
        sel_lvl       = req_lvl;
        info_o.served = level_i;
        if (level_ok && (32'(cnt_q[req_lvl]) < LEVEL_DEPTH)) begin
          do_push       = 1'b1;
          info_o.status = mlpq_pkg::ST_OK;
        end else begin
          info_o.status = mlpq_pkg::ST_FULL;
        end
      end
      mlpq_pkg::FN_PEEK: begin
        do_take = found;
      end
      mlpq_pkg::FN_POP_TOP: begin
        do_take = found;
        do_pop  = found;
      end
      mlpq_pkg::FN_POP_EXACT: begin
        sel_lvl = req_lvl;
        do_take = level_ok && nonempty[req_lvl];
        do_pop  = do_take;
      end
      mlpq_pkg::FN_POP_GE: begin
        do_take = level_ok && found;
        do_pop  = do_take;
      end
      default: begin
        do_take = 1'b0;
      end
    endcase
    if (do_take) begin
      info_o.take   = 1'b1;
      info_o.status = mlpq_pkg::ST_OK;
      info_o.served = mlpq_pkg::LEVEL_W'(sel_lvl);
    end
  end

  assign ptr        = do_push ? tail_q[sel_lvl] : head_q[sel_lvl];
  assign mem_addr_o = AW'(sel_lvl * LEVEL_DEPTH) + AW'(ptr);
  assign mem_we_o   = acc_i && do_push;
  assign mem_re_o   = acc_i && do_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (acc_i) begin
      if (do_push) begin
        tail_q[sel_lvl] <= (32'(tail_q[sel_lvl]) == LEVEL_DEPTH - 1) ? '0
                                                                     : tail_q[sel_lvl] + 1'b1;
        cnt_q[sel_lvl]  <= cnt_q[sel_lvl] + 1'b1;
      end
      if (do_pop) begin
        head_q[sel_lvl] <= (32'(head_q[sel_lvl]) == LEVEL_DEPTH - 1) ? '0
                                                                     : head_q[sel_lvl] + 1'b1;
        cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - 1'b1;
      end
    end
  end

endmodule

[src/multi_level_priority_fifo.sv]
// Timing: an accepted request passes the pending register with the entry memory
// registered read port, then the response registers. A new request is taken only
// when none is in flight and no held response is waiting on rsp_o.ready.
// Reset (rst_ni low, async): clears head/tail pointers, fill counts and the
// response valid flag. Entry memory is not cleared; no clearing pass.
module multi_level_priority_fifo #(
  parameter int NUM_LEVELS   = mlpq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH  = mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int PAYLOAD_BITS = mlpq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlpq_req_if.sink   req_i,
  mlpq_rsp_if.source rsp_o
);

  localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);
  localparam int DW = mlpq_pkg::DATA_W;

  logic                pend_q;
  mlpq_pkg::rsp_info_t info_d, info_q;
  logic                acc;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_addr;
  logic [PAYLOAD_BITS-1:0] rdata;

  logic                          out_valid_q;
  logic [mlpq_pkg::STATUS_W-1:0] status_q;
  logic [DW-1:0]                 data_q;
  logic [mlpq_pkg::LEVEL_W-1:0]  served_q;

  assign req_i.ready = !pend_q && (!out_valid_q || rsp_o.ready);
  assign acc         = req_i.valid && req_i.ready;

  mlpq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .func_i     (req_i.func),
    .level_i    (req_i.level),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .info_o     (info_d)
  );

  mlpq_store #(
    .DEPTH (NUM_LEVELS * LEVEL_DEPTH),
    .WIDTH (PAYLOAD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (PAYLOAD_BITS'(req_i.payload)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      info_q <= info_d;
    end
    if (pend_q) begin
      status_q <= info_q.status;
      served_q <= info_q.served;
      data_q   <= info_q.take ? DW'(rdata) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= acc;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.data_out     = data_q;
  assign rsp_o.served_level = served_q;

endmodule

[src/mlpq_checker.sv]
module mlpq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic [mlpq_pkg::FUNC_W-1:0]   req_func_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [mlpq_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [mlpq_pkg::DATA_W-1:0]   rsp_data_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i))
    else $error("response dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while previous one in flight");

  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##2 rsp_valid_i)
    else $error("response missing two cycles after request");

  a_push_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_func_i == mlpq_pkg::FN_PUSH) |-> ##2
      (rsp_status_i != mlpq_pkg::ST_EMPTY) && (rsp_data_i == '0))
    else $error("bad push response");

  a_bad_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_func_i > mlpq_pkg::FN_POP_GE) |-> ##2
      (rsp_status_i == mlpq_pkg::ST_EMPTY) && (rsp_data_i == '0))
    else $error("bad response to undefined func");

endmodule

bind multi_level_priority_fifo mlpq_checker u_mlpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_func_i   (req_i.func),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_data_i   (rsp_o.data_out)
);

[tb/sv/mlpq_response_checker.sv]
module mlpq_response_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mlpq_req_if  req_mon,
  mlpq_rsp_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEVELS   = mlpq_pkg::NUM_LEVELS_DEF;
  localparam int LEVEL_DEPTH  = mlpq_pkg::LEVEL_DEPTH_DEF;
  localparam int PAYLOAD_BITS = mlpq_pkg::PAYLOAD_BITS_DEF;
  localparam int DATA_W       = mlpq_pkg::DATA_W;
  localparam int LEVEL_W      = mlpq_pkg::LEVEL_W;
  localparam int FUNC_W       = mlpq_pkg::FUNC_W;
  localparam logic [DATA_W-1:0] PAYLOAD_MASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

  typedef struct packed {
    mlpq_pkg::status_e  status;
    logic [DATA_W-1:0]  data;
    logic [LEVEL_W-1:0] served;
  } rsp_expect_t;

  logic [DATA_W-1:0] ring_word [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned       ring_head [NUM_LEVELS];
  int unsigned       ring_tail [NUM_LEVELS];
  int unsigned       ring_fill [NUM_LEVELS];

  rsp_expect_t awaited_rsp[$];
  int          mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= LEVEL_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int highest_level(input int unsigned floor_lvl);
    for (int lv = NUM_LEVELS - 1; lv >= int'(floor_lvl); lv--) begin
      if (ring_fill[lv] != 0) return lv;
    end
    return -1;
  endfunction

  // applies one request to the level rings and returns the answer it earns
  function automatic rsp_expect_t serve_request(input logic [FUNC_W-1:0]  fn,
                                                input logic [LEVEL_W-1:0] lvl,
                                                input logic [DATA_W-1:0]  word);
    rsp_expect_t r;
    int          hit;
    r.status = mlpq_pkg::ST_EMPTY;
    r.data   = '0;
    r.served = '0;
    hit      = -1;
    case (fn)
      mlpq_pkg::FN_PUSH: begin
        r.served = lvl;
        if (lvl >= NUM_LEVELS || ring_fill[lvl] >= LEVEL_DEPTH) begin
          r.status = mlpq_pkg::ST_FULL;
        end else begin
          ring_word[lvl][ring_tail[lvl]] = word & PAYLOAD_MASK;
          ring_tail[lvl] = ring_next(ring_tail[lvl]);
          ring_fill[lvl]++;
          r.status = mlpq_pkg::ST_OK;
        end
      end
      mlpq_pkg::FN_PEEK, mlpq_pkg::FN_POP_TOP: hit = highest_level(0);
      mlpq_pkg::FN_POP_EXACT: begin
        if (lvl < NUM_LEVELS && ring_fill[lvl] != 0) hit = lvl;
      end
      mlpq_pkg::FN_POP_GE: begin
        if (lvl < NUM_LEVELS) hit = highest_level(lvl);
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.data   = ring_word[hit][ring_head[hit]];
      r.served = LEVEL_W'(hit);
      r.status = mlpq_pkg::ST_OK;
      if (fn != mlpq_pkg::FN_PEEK) begin
        ring_head[hit] = ring_next(ring_head[hit]);
        ring_fill[hit]--;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_expect_t e;
    if (!rst_ni) begin
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
        ring_head[lv] = 0;
        ring_tail[lv] = 0;
        ring_fill[lv] = 0;
      end
      awaited_rsp.delete();
      pending_o  = 0;
      mismatches = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("response with no request waiting");
        end else begin
          e = awaited_rsp.pop_front();
          if (rsp_mon.status !== e.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp_mon.status, e.status));
          if (rsp_mon.data_out !== e.data)
            report_mismatch($sformatf("data_out %h, predicted %h",
                                      rsp_mon.data_out, e.data));
          if (rsp_mon.served_level !== e.served)
            report_mismatch($sformatf("served_level %0d, predicted %0d",
                                      rsp_mon.served_level, e.served));
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_rsp.push_back(serve_request(req_mon.func, req_mon.level, req_mon.payload));
      pending_o = awaited_rsp.size();
    end
  end

endmodule

[tb/sv/tb_multi_level_priority_fifo.sv]
module tb_multi_level_priority_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1880;
  localparam int QUIET_ITEMS  = 250;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DATA_W       = mlpq_pkg::DATA_W;
  localparam int FUNC_W       = mlpq_pkg::FUNC_W;
  localparam int LEVEL_W      = mlpq_pkg::LEVEL_W;

  typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN, MODE_NARROW} traffic_mode_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   quiet;
  int   gap_pct;

  mlpq_req_if req_if ();
  mlpq_rsp_if rsp_if ();

  multi_level_priority_fifo dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mlpq_response_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input logic [FUNC_W-1:0]  fn,
                              input logic [LEVEL_W-1:0] lvl,
                              input logic [DATA_W-1:0]  word);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= fn;
    req_if.level   <= lvl;
    req_if.payload <= word;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // response side: random stall bursts, one long hold-off
  initial begin : rsp_drive
    int  cycles;
    int  len;
    bit  held;
    rsp_if.ready <= 1'b0;
    cycles = 0;
    held   = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && cycles >= HOLD_AT) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        len = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        len = $urandom_range(1, 7);
      end else begin
        rsp_if.ready <= 1'b1;
        len = $urandom_range(1, 12);
      end
      repeat (len) @(posedge clk_i);
      cycles += len;
    end
  end

  initial begin : stimulus
    traffic_mode_e    mode;
    int               run;
    int               pick;
    int               push_pct;
    logic [LEVEL_W-1:0] lvl_a;
    logic [LEVEL_W-1:0] lvl_b;
    logic [LEVEL_W-1:0] lvl;
    logic [FUNC_W-1:0]  fn;
    int               n;

    quiet          = 1'b0;
    gap_pct        = 25;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.func    <= mlpq_pkg::FN_PUSH;
    req_if.level   <= '0;
    req_if.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all empty, then unknown codes, then pushes and pops across levels
    send_request(mlpq_pkg::FN_PEEK, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_TOP, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_EXACT, 3'd3, rand_word());
    send_request(mlpq_pkg::FN_POP_GE, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_GE + 3'd1, 3'd7, '1);
    send_request(mlpq_pkg::FN_POP_GE + 3'd2, 3'd0, '1);
    send_request(mlpq_pkg::FN_POP_GE + 3'd3, 3'd7, '0);
    send_request(mlpq_pkg::FN_PUSH, 3'd0, '0);
    send_request(mlpq_pkg::FN_PUSH, 3'd7, '1);
    send_request(mlpq_pkg::FN_PUSH, 3'd3, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(mlpq_pkg::FN_PEEK, 3'd2, rand_word());
    send_request(mlpq_pkg::FN_POP_GE, 3'd4, rand_word());
    send_request(mlpq_pkg::FN_POP_GE, 3'd4, rand_word());
    send_request(mlpq_pkg::FN_POP_EXACT, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_TOP, 3'd6, rand_word());
    send_request(mlpq_pkg::FN_POP_EXACT, 3'd7, rand_word());
    send_request(mlpq_pkg::FN_PUSH, 3'd5, rand_word());
    send_request(mlpq_pkg::FN_PUSH, 3'd5, rand_word());
    send_request(mlpq_pkg::FN_POP_GE, 3'd7, rand_word());
    send_request(mlpq_pkg::FN_PEEK, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_TOP, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_TOP, 3'd0, rand_word());
    send_request(mlpq_pkg::FN_POP_TOP, 3'd0, rand_word());

    n = 0;
    while (n < RANDOM_ITEMS) begin
      mode    = traffic_mode_e'($urandom_range(0, 3));
      run     = $urandom_range(20, 60);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      lvl_a   = LEVEL_W'($urandom_range(0, 7));
      lvl_b   = LEVEL_W'($urandom_range(0, 7));
      case (mode)
        MODE_FILL:   push_pct = 75;
        MODE_DRAIN:  push_pct = 15;
        MODE_NARROW: push_pct = 65;
        default:     push_pct = 50;
      endcase
      for (int k = 0; k < run && n < RANDOM_ITEMS; k++) begin
        quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
        if (mode == MODE_NARROW)
          lvl = ($urandom_range(0, 1) == 0) ? lvl_a : lvl_b;
        else
          lvl = LEVEL_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 2)
          fn = mlpq_pkg::FN_POP_GE + FUNC_W'($urandom_range(1, 3));
        else if (pick < 2 + push_pct)
          fn = mlpq_pkg::FN_PUSH;
        else
          fn = mlpq_pkg::FN_PEEK + FUNC_W'($urandom_range(0, 3));
        send_request(fn, lvl, rand_word());
        n++;
      end
    end

    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
